// File: src/lcdn_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdn_pkg;

  localparam int WaitCounterBitsDefault = 17;
  localparam int QueueDepth = 2;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits = 17;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_DATA = 2'd2,
    REQ_INIT = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWERUP,
    PH_EHIGH,
    PH_SWAIT,
    PH_FINAL
  } phase_t;

  localparam logic [CfgIndexBits-1:0] CFG_POWERUP_WAIT = 3'd0;
  localparam logic [CfgIndexBits-1:0] CFG_ENABLE_HIGH  = 3'd1;
  localparam logic [CfgIndexBits-1:0] CFG_STROBE_WAIT  = 3'd2;
  localparam logic [CfgIndexBits-1:0] CFG_DATA_WAIT    = 3'd3;
  localparam logic [CfgIndexBits-1:0] CFG_COMMAND_WAIT = 3'd4;
  localparam logic [CfgIndexBits-1:0] CFG_INIT_FINAL   = 3'd5;

  localparam logic [3:0] INIT_NIBBLE_A = 4'h3;
  localparam logic [3:0] INIT_NIBBLE_B = 4'h2;
  localparam logic [2:0] INIT_STROBES = 3'd4;
  localparam logic [2:0] BYTE_STROBES = 3'd2;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] byte_val;
  } item_t;

  typedef struct packed {
    logic [16:0] powerup_wait_us;
    logic [7:0]  enable_high_us;
    logic [15:0] strobe_wait_us;
    logic [15:0] data_wait_us;
    logic [15:0] command_wait_us;
    logic [15:0] init_final_wait_us;
  } cfg_t;

  typedef struct packed {
    logic       enable_pin;
    logic       select_pin;
    logic [3:0] bus_nibble;
    logic       busy_res;
    logic       accepted;
  } result_t;

endpackage

// File: src/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit bus sequencer.
//
// Usage: every request on the input channel is a one-microsecond tick
// (req_type 0), a command byte (1), a data byte (2) or an init request (3).
// Each request gives exactly one request on the output channel with the
// enable, select and D4..D7 levels after it, the busy flag and whether
// it started a new sequence. A byte or init request that arrives while a
// sequence is running is rejected and does not count as a tick.
// Timing: a request passes the input stage, a two-entry queue and the
// engine's output register before its result is valid. One request per
// cycle is sustained while the output side takes results; the engine steps
// one request per cycle through its phase counter.
// Stalls: when the output side holds off, the result waits in the output
// register while the queue and input stage keep taking requests until
// they fill, after which in_ready drops.
// Reset: rst is synchronous; it empties the stages, returns the engine to
// idle and loads the default wait registers; the pins keep the last result.
// Configuration writes are taken every cycle and are meant for idle time.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer #(
  parameter int WAIT_COUNTER_BITS = lcdn_pkg::WaitCounterBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic [7:0]                         byte_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               enable_pin,
  output logic                               select_pin,
  output logic [3:0]                         bus_nibble,
  output logic                               busy_res,
  output logic                               accepted,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcdn_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [lcdn_pkg::CfgDataBits-1:0]   cfg_data
);
  import lcdn_pkg::*;

  cfg_t    cfg;
  item_t   front_item;
  item_t   queue_item;
  result_t res;
  logic    front_valid, front_ready;
  logic    queue_valid, queue_ready;

  // The wait registers are plain storage; writes never stall.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.powerup_wait_us    <= 17'd50000;
      cfg.enable_high_us     <= 8'd1;
      cfg.strobe_wait_us     <= 16'd2000;
      cfg.data_wait_us       <= 16'd50;
      cfg.command_wait_us    <= 16'd40;
      cfg.init_final_wait_us <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POWERUP_WAIT: cfg.powerup_wait_us    <= cfg_data[16:0];
        CFG_ENABLE_HIGH:  cfg.enable_high_us     <= cfg_data[7:0];
        CFG_STROBE_WAIT:  cfg.strobe_wait_us     <= cfg_data[15:0];
        CFG_DATA_WAIT:    cfg.data_wait_us       <= cfg_data[15:0];
        CFG_COMMAND_WAIT: cfg.command_wait_us    <= cfg_data[15:0];
        CFG_INIT_FINAL:   cfg.init_final_wait_us <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lcdn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .byte_value (byte_value),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  lcdn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_item  (queue_item)
  );

  lcdn_back #(
    .WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign enable_pin = res.enable_pin;
  assign select_pin = res.select_pin;
  assign bus_nibble = res.bus_nibble;
  assign busy_res   = res.busy_res;
  assign accepted   = res.accepted;

endmodule

// File: src/lcdn_front.sv
// Input stage: takes requests and classifies them into queue entries.
`timescale 1ns / 1ps

module lcdn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         byte_value,
  output logic               item_valid,
  input  logic               item_ready,
  output lcdn_pkg::item_t    item
);
  import lcdn_pkg::*;

  logic  stage_valid;
  item_t stage_item;

  assign in_ready   = !stage_valid || item_ready;
  assign item_valid = stage_valid;
  assign item       = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item.kind     <= req_kind_t'(req_type);
      stage_item.byte_val <= byte_value;
    end
  end

endmodule

// File: src/lcdn_queue.sv
// Short request queue between the input stage and the sequencing engine.
`timescale 1ns / 1ps

module lcdn_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  lcdn_pkg::item_t    wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output lcdn_pkg::item_t    rd_item
);
  import lcdn_pkg::*;

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountBits = $clog2(QueueDepth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QueueDepth - 1);
  localparam logic [CountBits-1:0] FullCount = CountBits'(QueueDepth);

  item_t                mem [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CountBits-1:0] count;
  logic                 push;
  logic                 pop;

  assign wr_ready = (count != FullCount);
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/lcdn_back.sv
// Sequencing engine: steps the strobe and wait phases and registers each result.
`timescale 1ns / 1ps

module lcdn_back #(
  parameter int WAIT_COUNTER_BITS = lcdn_pkg::WaitCounterBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  lcdn_pkg::cfg_t     cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  lcdn_pkg::item_t    item,
  output logic               out_valid,
  input  logic               out_ready,
  output lcdn_pkg::result_t  res
);
  import lcdn_pkg::*;

  localparam int W = WAIT_COUNTER_BITS;

  function automatic logic [W-1:0] sat_wait(input logic [31:0] v);
    logic [31:0] hi;
    hi = v >> W;
    return (hi != '0) ? {W{1'b1}} : v[W-1:0];
  endfunction

  phase_t     phase, phase_next;
  logic [W-1:0] wait_count, wait_count_next;
  logic [2:0] strobes_left, strobes_left_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_select, held_select_next;
  req_kind_t  request_kind, request_kind_next;
  logic [3:0] nibble_out, nibble_out_next;
  logic       enable_out, enable_out_next;
  logic       acc;
  logic       do_strobe;
  logic       do_final;
  logic [W-1:0] final_wait;
  logic       pop;
  result_t    res_next;

  logic [W-1:0] powerup_sat, enable_sat, strobe_sat;
  assign powerup_sat = sat_wait(32'(cfg.powerup_wait_us));
  assign enable_sat  = sat_wait(32'(cfg.enable_high_us));
  assign strobe_sat  = sat_wait(32'(cfg.strobe_wait_us));

  assign pop        = item_valid && (!out_valid || out_ready);
  assign item_ready = !out_valid || out_ready;

  // Next state: one queued item per cycle while the output is not stalled, with zero-length waits chained.
  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    strobes_left_next = strobes_left;
    held_byte_next    = held_byte;
    held_select_next  = held_select;
    request_kind_next = request_kind;
    nibble_out_next   = nibble_out;
    enable_out_next   = enable_out;
    acc               = 1'b0;
    do_strobe         = 1'b0;
    do_final          = 1'b0;
    final_wait        = '0;
    if (pop) begin
      if (item.kind == REQ_TICK) begin
        if (phase != PH_IDLE) begin
          if (wait_count > W'(1)) begin
            wait_count_next = wait_count - 1'b1;
          end else begin
            wait_count_next = '0;
            unique case (phase)
              PH_POWERUP: do_strobe = 1'b1;
              PH_EHIGH: begin
                enable_out_next = 1'b0;
                if (strobes_left != '0) begin
                  strobes_left_next = strobes_left - 1'b1;
                end
                if (strobe_sat == '0) begin
                  if (strobes_left_next != '0) begin
                    do_strobe = 1'b1;
                  end else begin
                    do_final = 1'b1;
                  end
                end else begin
                  phase_next      = PH_SWAIT;
                  wait_count_next = strobe_sat;
                end
              end
              PH_SWAIT: begin
                if (strobes_left != '0) begin
                  do_strobe = 1'b1;
                end else begin
                  do_final = 1'b1;
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
      end else if (phase == PH_IDLE) begin
        acc               = 1'b1;
        request_kind_next = item.kind;
        if (item.kind == REQ_INIT) begin
          held_select_next  = 1'b0;
          held_byte_next    = '0;
          strobes_left_next = INIT_STROBES;
          if (powerup_sat == '0) begin
            do_strobe = 1'b1;
          end else begin
            phase_next      = PH_POWERUP;
            wait_count_next = powerup_sat;
          end
        end else begin
          held_select_next  = (item.kind == REQ_DATA);
          held_byte_next    = item.byte_val;
          strobes_left_next = BYTE_STROBES;
          do_strobe         = 1'b1;
        end
      end
    end

    if (do_strobe) begin
      if (request_kind_next == REQ_INIT) begin
        nibble_out_next = (strobes_left_next == 3'd1) ? INIT_NIBBLE_B : INIT_NIBBLE_A;
      end else if (strobes_left_next >= 3'd2) begin
        nibble_out_next = held_byte_next[7:4];
      end else begin
        nibble_out_next = held_byte_next[3:0];
      end
      enable_out_next = 1'b1;
      phase_next      = PH_EHIGH;
      wait_count_next = enable_sat;
    end

    if (do_final) begin
      case (request_kind_next)
        REQ_CMD:  final_wait = sat_wait(32'(cfg.command_wait_us));
        REQ_DATA: final_wait = sat_wait(32'(cfg.data_wait_us));
        default:  final_wait = sat_wait(32'(cfg.init_final_wait_us));
      endcase
      if (final_wait == '0) begin
        phase_next      = PH_IDLE;
        wait_count_next = '0;
      end else begin
        phase_next      = PH_FINAL;
        wait_count_next = final_wait;
      end
    end
  end

  // Result fields as they stand after the item.
  always_comb begin
    res_next.enable_pin = enable_out_next;
    res_next.select_pin = held_select_next;
    res_next.bus_nibble = nibble_out_next;
    res_next.busy_res   = (phase_next != PH_IDLE);
    res_next.accepted   = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_count   <= '0;
      strobes_left <= '0;
      held_byte    <= '0;
      held_select  <= 1'b0;
      request_kind <= REQ_TICK;
      nibble_out   <= '0;
      enable_out   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      strobes_left <= strobes_left_next;
      held_byte    <= held_byte_next;
      held_select  <= held_select_next;
      request_kind <= request_kind_next;
      nibble_out   <= nibble_out_next;
      enable_out   <= enable_out_next;
      if (item_ready) begin
        out_valid <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule

// File: src/lcdn_checker.sv
// Port-level checks for the character LCD nibble sequencer, bound to the top level.
`timescale 1ns / 1ps

module lcdn_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] req_type,
  input logic [7:0] byte_value,
  input logic       out_valid,
  input logic       out_ready,
  input logic       enable_pin,
  input logic       select_pin,
  input logic [3:0] bus_nibble,
  input logic       busy_res,
  input logic       accepted,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] cfg_index,
  input logic [16:0] cfg_data
);

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(enable_pin) &&
      $stable(select_pin) && $stable(bus_nibble) && $stable(busy_res) &&
      $stable(accepted))
    else $error("result changed while stalled");

  // A request that starts a sequence always leaves the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> busy_res)
    else $error("accepted request without busy");

  // The enable strobe is only ever high inside a running sequence.
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_pin |-> busy_res)
    else $error("enable high while idle");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind char_lcd_nibble_sequencer lcdn_checker u_lcdn_checker (.*);
